// ----- rtl/payload_signature_matcher_macros.svh -----
// Assertion helpers for the payload signature matcher.
`ifndef PAYLOAD_SIGNATURE_MATCHER_MACROS_SVH
`define PAYLOAD_SIGNATURE_MATCHER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked only while out of reset
`define PSM_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("payload_signature_matcher: assertion failed");

// Checked on every edge, reset included
`define PSM_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("payload_signature_matcher: assertion failed");

`else

`define PSM_ASSERT(label, prop)
`define PSM_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ----- rtl/psm_pkg.sv -----
package psm_pkg;

  localparam int NSIG       = 15;
  localparam int HIST_DEPTH = 12;
  localparam int WIN_BYTES  = HIST_DEPTH + 1;
  localparam int WIN_W      = 8 * WIN_BYTES;
  localparam int HIST_W     = 8 * HIST_DEPTH;
  localparam int CFG_W      = 16;
  localparam int CNT_W      = 16;
  localparam int IDX_W      = 4;

  // Register indexes of the configuration port
  typedef enum logic [0:0] {
    CFG_SCAN_LIMIT = 1'b0,
    CFG_MIN_LENGTH = 1'b1
  } psm_cfg_idx_e;

  localparam logic [CFG_W-1:0] SCAN_LIMIT_RST = 16'd1024;
  localparam logic [CFG_W-1:0] MIN_LENGTH_RST = 16'd8;

  // Signature text, right aligned: the last character sits in bits [7:0],
  // so byte j of the window (j bytes back) lines up with bits [8j +: 8].
  localparam logic [WIN_W-1:0] SIG_TEXT [NSIG] = '{
    WIN_W'("/bin/sh"),
    WIN_W'("/bin/bash"),
    WIN_W'("cmd.exe"),
    WIN_W'("powershell"),
    WIN_W'("eval("),
    WIN_W'("exec("),
    WIN_W'("system("),
    WIN_W'("SELECT * FROM"),
    WIN_W'("UNION SELECT"),
    WIN_W'("' OR '1'='1"),
    WIN_W'("../../../"),
    WIN_W'("../../../../"),
    WIN_W'("<script"),
    WIN_W'("javascript:"),
    WIN_W'("alert(")
  };

  localparam logic [IDX_W-1:0] SIG_LEN [NSIG] = '{
    4'd7, 4'd9, 4'd7, 4'd10, 4'd5, 4'd5, 4'd7, 4'd13,
    4'd12, 4'd11, 4'd9, 4'd12, 4'd7, 4'd11, 4'd6
  };

  // One queue entry: what the scanner learned about a finished packet
  typedef struct packed {
    logic [NSIG-1:0] mask;
    logic            long_enough;
  } psm_entry_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } psm_q_status_t;

  // Signature s ends at the current byte; count is the bytes scanned before it
  function automatic logic sig_hit(input int s, input logic [WIN_W-1:0] win,
                                   input logic [CNT_W-1:0] count);
    logic [WIN_W-1:0] m;
    logic [CNT_W-1:0] need;
    m    = {WIN_W{1'b1}} >> (WIN_W - 8 * int'(SIG_LEN[s]));
    need = {{(CNT_W-IDX_W){1'b0}}, SIG_LEN[s]} - CNT_W'(1);
    return ((win & m) == SIG_TEXT[s]) && (count >= need);
  endfunction

endpackage

// ----- rtl/psm_if.sv -----
// Payload byte channel
interface psm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last_byte;

  modport source (output valid, output data_byte, output byte_valid,
                  output last_byte, input ready);
  modport sink   (input valid, input data_byte, input byte_valid,
                  input last_byte, output ready);
endinterface

// Per-packet result channel
interface psm_out_if;
  logic       valid;
  logic       ready;
  logic       threat_found;
  logic [3:0] signature_index;

  modport source (output valid, output threat_found, output signature_index,
                  input ready);
  modport sink   (input valid, input threat_found, input signature_index,
                  output ready);
endinterface

// ----- rtl/payload_signature_matcher.sv -----
// Payload signature matcher: takes one payload byte per item and one item
// per clock, comparing the newest 13 bytes against 15 fixed signatures
// combinationally. On the item marked last_byte the hit mask and length
// flag go into a small queue of QueueDepth packets; a resolver pops them
// into the output register as found flag and lowest matching index. Input
// is stalled only when the queue is full, which happens when results are
// not taken while short packets keep arriving. scan_limit and min_length
// are to be written only while idle; the block does not enforce it.
`include "payload_signature_matcher_macros.svh"

module payload_signature_matcher import psm_pkg::*; #(
  parameter int QueueDepth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  psm_in_if.sink           in_s,
  psm_out_if.source        out_m
);

  logic          push;
  logic          pop;
  psm_entry_t    push_entry;
  psm_entry_t    pop_entry;
  psm_q_status_t q_status;

  // Front: scan bytes, collect hits per packet
  psm_scanner u_scanner (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_s         (in_s),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // Packet results waiting for the back end
  psm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry),
    .status_o     (q_status)
  );

  // Back: pick lowest hit and drive the result
  psm_resolver u_resolver (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .entry_i    (pop_entry),
    .pop_o      (pop),
    .out_m      (out_m)
  );

  `PSM_ASSERT(a_no_push_when_full, push |-> !q_status.full)
  `PSM_ASSERT(a_no_pop_when_empty, pop |-> !q_status.empty)
  `PSM_ASSERT(a_index_zero_if_clean,
              out_m.valid && !out_m.threat_found |-> out_m.signature_index == 4'd0)
  `PSM_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_m.valid && q_status.empty)

endmodule

// ----- rtl/psm_scanner.sv -----
module psm_scanner import psm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  psm_in_if.sink               in_s,
  input  psm_q_status_t        q_status_i,
  output logic                 push_o,
  output psm_entry_t           push_entry_o
);

  logic [CFG_W-1:0]  scan_limit_q;
  logic [CFG_W-1:0]  min_length_q;
  logic [HIST_W-1:0] hist_q, hist_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [NSIG-1:0]   mask_q, mask_d;

  logic              accept;
  logic              scan;
  logic [WIN_W-1:0]  window;
  logic [NSIG-1:0]   hits;
  logic [NSIG-1:0]   mask_upd;
  logic [CNT_W-1:0]  count_upd;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_limit_q <= SCAN_LIMIT_RST;
      min_length_q <= MIN_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (psm_cfg_idx_e'(cfg_idx_i))
        CFG_SCAN_LIMIT: scan_limit_q <= cfg_wdata_i;
        CFG_MIN_LENGTH: min_length_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Accept whenever the queue has room for a packet result
  assign in_s.ready = !q_status_i.full;
  assign accept     = in_s.valid && in_s.ready;
  assign scan       = accept && in_s.byte_valid && (count_q < scan_limit_q);
  assign window     = {hist_q, in_s.data_byte};

  // Parallel compare of every signature ending at this byte
  always_comb begin
    for (int s = 0; s < NSIG; s++) begin
      hits[s] = sig_hit(s, window, count_q);
    end
  end

  assign mask_upd  = scan ? (mask_q | hits) : mask_q;
  assign count_upd = scan ? (count_q + CNT_W'(1)) : count_q;

  // Packet state update, cleared after the last item
  always_comb begin
    hist_d  = hist_q;
    count_d = count_upd;
    mask_d  = mask_upd;
    if (scan) begin
      hist_d = {hist_q[HIST_W-9:0], in_s.data_byte};
    end
    if (accept && in_s.last_byte) begin
      hist_d  = '0;
      count_d = '0;
      mask_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q  <= '0;
      count_q <= '0;
      mask_q  <= '0;
    end else begin
      hist_q  <= hist_d;
      count_q <= count_d;
      mask_q  <= mask_d;
    end
  end

  // Hand the finished packet to the queue
  assign push_o                   = accept && in_s.last_byte;
  assign push_entry_o.mask        = mask_upd;
  assign push_entry_o.long_enough = (count_upd >= min_length_q);

endmodule

// ----- rtl/psm_queue.sv -----
module psm_queue import psm_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  psm_entry_t    push_entry_i,
  input  logic          pop_i,
  output psm_entry_t    pop_entry_o,
  output psm_q_status_t status_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  psm_entry_t        mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   fill_q;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  assign pop_entry_o = mem_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - CntW'(1);
      end
    end
  end

  assign status_o.full  = (fill_q == CntW'(Depth));
  assign status_o.empty = (fill_q == '0);

endmodule

// ----- rtl/psm_resolver.sv -----
module psm_resolver import psm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  psm_q_status_t q_status_i,
  input  psm_entry_t    entry_i,
  output logic          pop_o,
  psm_out_if.source     out_m
);

  logic             valid_q, valid_d;
  logic             found_q;
  logic [IDX_W-1:0] index_q;
  logic             found_d;
  logic [IDX_W-1:0] index_d;

  // Take the next packet when the output register is free or drains
  assign pop_o = !q_status_i.empty && (!valid_q || out_m.ready);

  // Lowest set bit of the hit mask
  always_comb begin
    index_d = '0;
    for (int s = NSIG - 1; s >= 0; s--) begin
      if (entry_i.mask[s]) begin
        index_d = IDX_W'(s);
      end
    end
    found_d = entry_i.long_enough && (entry_i.mask != '0);
    if (!found_d) begin
      index_d = '0;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (out_m.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      found_q <= found_d;
      index_q <= index_d;
    end
  end

  assign out_m.valid           = valid_q;
  assign out_m.threat_found    = found_q;
  assign out_m.signature_index = index_q;

endmodule

// ----- tb/sv/payload_signature_matcher_tb.sv -----
module payload_signature_matcher_tb;
  import psm_pkg::*;

  localparam int STALL_LIMIT  = 2000;  // cycles with no item moving on either side
  localparam int SETTLE_CYCLES = 8;    // result latency plus margin
  localparam int PHASE_ITEMS  = 135;   // minimum random items per phase

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;
  } pay_item_t;

  typedef struct packed {
    logic       threat_found;
    logic [3:0] signature_index;
  } verdict_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  psm_cfg_idx_e     cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  psm_in_if  in_if ();
  psm_out_if out_if ();

  payload_signature_matcher i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_s        (in_if),
    .out_m       (out_if)
  );

  // Signature table, in priority order
  string sig_tab [NSIG] = '{
    "/bin/sh", "/bin/bash", "cmd.exe", "powershell", "eval(", "exec(",
    "system(", "SELECT * FROM", "UNION SELECT", "' OR '1'='1",
    "../../../", "../../../../", "<script", "javascript:", "alert("
  };

  // Predictor state and its copy of the registers
  logic [CFG_W-1:0] scan_lim;
  logic [CFG_W-1:0] min_len;
  logic [7:0]       payload_hist [HIST_DEPTH];
  logic [CNT_W-1:0] scanned_bytes;
  logic [NSIG-1:0]  sig_hits_mask;

  pay_item_t pend_items [$];
  verdict_t  expected_verdicts [$];
  int        send_idle_pct;
  int        recv_stall_pct;
  int        mismatch_count;
  int        stall_cycles;
  int        queued_items;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_packet();
    for (int k = 0; k < HIST_DEPTH; k++) payload_hist[k] = '0;
    scanned_bytes = '0;
    sig_hits_mask = '0;
  endfunction

  // Advance the scanner by one item; returns 1 when the item closes a packet
  function automatic bit scan_step(input pay_item_t it, output verdict_t v);
    logic [7:0] win [HIST_DEPTH+1];
    int len;
    bit hit;
    v = '0;
    if (it.byte_valid && scanned_bytes < scan_lim) begin
      win[0] = it.data_byte;
      for (int k = 0; k < HIST_DEPTH; k++) win[k+1] = payload_hist[k];
      for (int s = 0; s < NSIG; s++) begin
        len = sig_tab[s].len();
        // signature must fit in the bytes scanned so far, this one included
        hit = (int'(scanned_bytes) + 1 >= len);
        for (int j = 0; j < len; j++)
          if (win[j] != 8'(sig_tab[s][len-1-j])) hit = 1'b0;
        if (hit) sig_hits_mask[s] = 1'b1;
      end
      for (int k = HIST_DEPTH - 1; k > 0; k--) payload_hist[k] = payload_hist[k-1];
      payload_hist[0] = it.data_byte;
      scanned_bytes = scanned_bytes + 1'b1;
    end
    if (!it.last_byte) return 1'b0;
    if (scanned_bytes >= min_len && sig_hits_mask != '0) begin
      v.threat_found = 1'b1;
      for (int s = NSIG - 1; s >= 0; s--)
        if (sig_hits_mask[s]) v.signature_index = 4'(s);
    end
    clear_packet();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Payload driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_payload
    pay_item_t nxt;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (pend_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pend_items.pop_front();
        in_if.valid      <= 1'b1;
        in_if.data_byte  <= nxt.data_byte;
        in_if.byte_valid <= nxt.byte_valid;
        in_if.last_byte  <= nxt.last_byte;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check results, then predict from the accepted byte
  always @(posedge clk_i) begin : check_results
    verdict_t  got;
    verdict_t  want;
    verdict_t  pred;
    pay_item_t it;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got.threat_found    = out_if.threat_found;
        got.signature_index = out_if.signature_index;
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("result with none pending: found=%0b idx=%0d",
                                    got.threat_found, got.signature_index));
        end else begin
          want = expected_verdicts.pop_front();
          if (got.threat_found !== want.threat_found)
            report_mismatch($sformatf("threat_found %0b, predicted %0b",
                                      got.threat_found, want.threat_found));
          if (got.signature_index !== want.signature_index)
            report_mismatch($sformatf("signature_index %0d, predicted %0d",
                                      got.signature_index, want.signature_index));
        end
      end
      if (in_if.valid && in_if.ready) begin
        it.data_byte  = in_if.data_byte;
        it.byte_valid = in_if.byte_valid;
        it.last_byte  = in_if.last_byte;
        if (scan_step(it, pred)) expected_verdicts.push_back(pred);
      end
    end
  end

  // Watchdog: nothing moving for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("** payload_signature_matcher: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_item(input logic [7:0] b, input logic v, input logic last);
    pay_item_t it;
    it.data_byte  = b;
    it.byte_valid = v;
    it.last_byte  = last;
    pend_items.push_back(it);
    queued_items++;
  endtask

  task automatic push_text(input string txt, input logic last);
    for (int k = 0; k < txt.len(); k++)
      push_item(8'(txt[k]), 1'b1, last && (k == txt.len() - 1));
  endtask

  // Half random bytes, half letters taken from signatures for near misses
  function automatic logic [7:0] filler_byte();
    int s;
    if ($urandom_range(1)) return 8'($urandom_range(255));
    s = $urandom_range(NSIG - 1);
    return 8'(sig_tab[s][$urandom_range(sig_tab[s].len() - 1)]);
  endfunction

  task automatic plant_sig(ref logic [7:0] body [$]);
    int s;
    int len;
    logic [7:0] chunk [$];
    s   = $urandom_range(NSIG - 1);
    len = sig_tab[s].len();
    for (int k = 0; k < len; k++) chunk.push_back(8'(sig_tab[s][k]));
    // sometimes a damaged copy: one byte changed or tail cut off
    if ($urandom_range(4) == 0) chunk[$urandom_range(len - 1)] = filler_byte();
    else if ($urandom_range(9) == 0) void'(chunk.pop_back());
    foreach (chunk[k]) body.push_back(chunk[k]);
  endtask

  // One packet: filler, planted signatures, filler; some invalid bytes; now and then a lone invalid last item
  task automatic queue_packet(input int pad);
    logic [7:0] body [$];
    int n;
    if ($urandom_range(19) == 0) begin
      push_item(8'($urandom_range(255)), 1'b0, 1'b1);
      return;
    end
    n = $urandom_range(pad);
    for (int k = 0; k < n; k++) body.push_back(filler_byte());
    if ($urandom_range(9) < 8) plant_sig(body);
    if ($urandom_range(4) == 0) plant_sig(body);
    n = $urandom_range(pad);
    for (int k = 0; k < n; k++) body.push_back(filler_byte());
    if (body.size() == 0) body.push_back(filler_byte());
    foreach (body[k]) begin
      if ($urandom_range(19) == 0)
        push_item(8'($urandom_range(255)), 1'b0, 1'b0);
      push_item(body[k], ($urandom_range(24) != 0), k == body.size() - 1);
    end
  endtask

  task automatic write_reg(input psm_cfg_idx_e idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SCAN_LIMIT: scan_lim = val;
      CFG_MIN_LENGTH: min_len  = val;
      default: ;
    endcase
  endtask

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 74; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 74; end
      default:   begin send_idle_pct = 8;  recv_stall_pct = 8;  end
    endcase
  endtask

  // Sender holds off until the queue is empty and every result is back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pend_items.size() != 0 || in_if.valid || expected_verdicts.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Stimulus sequence
  initial begin : stimulus
    logic [CFG_W-1:0] lim_tab [8];
    logic [CFG_W-1:0] min_tab [8];
    idle_mode_e       mode_tab [8];
    int               pad_tab [8];
    lim_tab  = '{16'd1024, 16'd0, 16'd65535, 16'd12, 16'd20, 16'd1, 16'd16, 16'd65535};
    min_tab  = '{16'd8, 16'd0, 16'd0, 16'd0, 16'd65535, 16'd0, 16'd5, 16'd13};
    mode_tab = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                 IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE};
    pad_tab  = '{8, 6, 10, 12, 12, 4, 10, 8};

    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_SCAN_LIMIT;
    cfg_wdata_i      = '0;
    in_if.valid      = 1'b0;
    in_if.data_byte  = '0;
    in_if.byte_valid = 1'b0;
    in_if.last_byte  = 1'b0;
    out_if.ready     = 1'b0;
    mismatch_count   = 0;
    queued_items     = 0;
    scan_lim         = SCAN_LIMIT_RST;
    min_len          = MIN_LENGTH_RST;
    clear_packet();
    set_idle(IDLE_NONE);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset register values
    push_item(8'h5a, 1'b0, 1'b1);            // empty payload marker
    push_item(8'h00, 1'b1, 1'b0);            // match with an invalid byte inside
    push_item(8'hff, 1'b1, 1'b0);
    push_text("eva", 1'b0);
    push_item(8'ha5, 1'b0, 1'b0);
    push_text("l(", 1'b0);
    push_item(8'hff, 1'b1, 1'b1);
    push_text("exec(", 1'b1);                // short packet, not flagged
    push_text("sys", 1'b1);                  // split across a packet boundary
    push_text("tem(....", 1'b1);
    wait_drained();

    // Random phases, each with its own register setting and idle pattern
    for (int p = 0; p < 8; p++) begin
      if (p != 0) begin
        write_reg(CFG_SCAN_LIMIT, lim_tab[p]);
        write_reg(CFG_MIN_LENGTH, min_tab[p]);
      end
      @(negedge clk_i);
      set_idle(mode_tab[p]);
      queued_items = 0;
      while (queued_items < PHASE_ITEMS) queue_packet(pad_tab[p]);
      wait_drained();
    end

    set_idle(IDLE_NONE);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** payload_signature_matcher: PASSED **");
    end else begin
      $display("** payload_signature_matcher: FAILED **");
    end
    $finish;
  end

endmodule
